FILE: rtl/core/rgb_box_blur_3x3_top_assert.svh
// Assertion macros for the 3x3 box blur pipeline.
// The using module must have i_clk and i_rst_n in scope.
`ifndef RGB_BOX_BLUR_3X3_TOP_ASSERT_SVH
`define RGB_BOX_BLUR_3X3_TOP_ASSERT_SVH

// Checked at every clock edge outside reset.
`define BBX_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every clock edge, reset cycles included.
`define BBX_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: rtl/core/bbx_pkg.sv
// Shared types, constants and helper functions for the 3x3 box blur.
// No dependencies; all but bbx_ram and the assertion header import it.
`timescale 1ns / 1ps

package bbx_pkg;

    localparam int PIX_W      = 8;
    localparam int RGB_W      = 3 * PIX_W;
    localparam int ROW_W      = 16;
    localparam int OCOL_W     = 10;
    localparam int FW_W       = 11;
    localparam int FH_W       = 16;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = 12;
    localparam int MIN_SIDE   = 3;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 16'd480;

    // floor(s / 9) == (s * 1821) >> 14 for every sum of nine bytes
    localparam int              DIV9_MUL_W = 11;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 11'd1821;
    localparam int              DIV9_SHIFT = 14;
    localparam int              PROD_W     = SUM_W + DIV9_MUL_W;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    // position and result flags of one item
    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        logic              has_blur;
        logic              has_pass;
    } t_pos;

    // item handed from the window stage to the result stage
    typedef struct packed {
        t_pos             pos;
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        t_rgb             px;
    } t_s2;

    function automatic logic [SUM_W-1:0] ext_pix(input logic [PIX_W-1:0] v);
        return SUM_W'(v);
    endfunction

    // adder tree over the nine window taps of one channel
    function automatic logic [SUM_W-1:0] sum9(input logic [8:0][PIX_W-1:0] v);
        logic [SUM_W-1:0] s01;
        logic [SUM_W-1:0] s23;
        logic [SUM_W-1:0] s45;
        logic [SUM_W-1:0] s67;
        s01 = ext_pix(v[0]) + ext_pix(v[1]);
        s23 = ext_pix(v[2]) + ext_pix(v[3]);
        s45 = ext_pix(v[4]) + ext_pix(v[5]);
        s67 = ext_pix(v[6]) + ext_pix(v[7]);
        return (s01 + s23) + (s45 + s67) + ext_pix(v[8]);
    endfunction

    // divide by nine through a reciprocal multiply
    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(s) * PROD_W'(DIV9_MUL);
        return prod[DIV9_SHIFT +: PIX_W];
    endfunction

endpackage

FILE: rtl/core/bbx_pix_if.sv
// Valid/ready stream interfaces for pixel items in and result items out.
// Depends on bbx_pkg for field widths.
`timescale 1ns / 1ps

interface bbx_pix_in_if;
    import bbx_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;

    modport source (output valid, in_red, in_green, in_blue, input ready);
    modport sink   (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface bbx_pix_out_if;
    import bbx_pkg::*;

    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  out_row;
    logic [OCOL_W-1:0] out_col;
    logic [PIX_W-1:0]  out_red;
    logic [PIX_W-1:0]  out_green;
    logic [PIX_W-1:0]  out_blue;
    logic              last_in_run;

    modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                    last_in_run, input ready);
    modport sink   (input valid, out_row, out_col, out_red, out_green, out_blue,
                    last_in_run, output ready);
endinterface

FILE: rtl/core/bbx_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
`timescale 1ns / 1ps

module bbx_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while the read enable is low
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/bbx_pos.sv
// Raster position tracker: row/column of the incoming item and its result flags.
// Depends on bbx_pkg.
`timescale 1ns / 1ps

module bbx_pos #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [bbx_pkg::FW_W-1:0]     i_frame_width,
    input  logic [bbx_pkg::FH_W-1:0]     i_frame_height,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col,
    output bbx_pkg::t_pos                o_tag
);
    import bbx_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int EW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (EW_W > FW_W) ? EW_W : FW_W;

    localparam logic [CMP_W-1:0] W_MAX = CMP_W'(MAX_WIDTH);
    localparam logic [CMP_W-1:0] W_MIN = CMP_W'(MIN_SIDE);
    localparam logic [FH_W-1:0]  H_MIN = FH_W'(MIN_SIDE);

    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [CW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;

    logic [CMP_W-1:0] w_fw;
    logic [CMP_W-1:0] w_ew;
    logic [FH_W-1:0]  w_eh;
    logic [CMP_W-1:0] w_col_cur;
    logic             w_wrap_pre;
    logic [CMP_W-1:0] w_c;
    logic [ROW_W:0]   w_row_pre;
    logic [ROW_W-1:0] w_r;
    logic [CMP_W-1:0] w_c_inc;
    logic [ROW_W:0]   w_r_inc;

    // effective frame size
    always_comb begin
        w_fw = CMP_W'(i_frame_width);
        if (w_fw < W_MIN) begin
            w_ew = W_MIN;
        end else if (w_fw > W_MAX) begin
            w_ew = W_MAX;
        end else begin
            w_ew = w_fw;
        end
        w_eh = (i_frame_height < H_MIN) ? H_MIN : i_frame_height;
    end

    // position of this item; a shrunk frame ends the row or frame early
    always_comb begin
        w_col_cur  = CMP_W'(r_col);
        w_wrap_pre = (w_col_cur >= w_ew);
        w_c        = w_wrap_pre ? '0 : w_col_cur;
        w_row_pre  = w_wrap_pre ? ({1'b0, r_row} + (ROW_W + 1)'(1)) : {1'b0, r_row};
        w_r        = (w_row_pre >= {1'b0, w_eh}) ? '0 : w_row_pre[ROW_W-1:0];
    end

    // position of the following item
    always_comb begin
        w_c_inc = w_c + CMP_W'(1);
        w_r_inc = {1'b0, w_r} + (ROW_W + 1)'(1);
        if (w_c_inc >= w_ew) begin
            n_col = '0;
            n_row = (w_r_inc >= {1'b0, w_eh}) ? '0 : w_r_inc[ROW_W-1:0];
        end else begin
            n_col = w_c_inc[CW-1:0];
            n_row = w_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // blurred result of (r-1,c-1) once the window is full; border passes through
    always_comb begin
        o_col          = w_c[CW-1:0];
        o_tag.row      = w_r;
        o_tag.col      = w_c[OCOL_W-1:0];
        o_tag.has_blur = (w_r >= ROW_W'(2)) && (w_c >= CMP_W'(2));
        o_tag.has_pass = (w_r == '0) || (w_r == (w_eh - FH_W'(1)))
                      || (w_c == '0) || (w_c == (w_ew - CMP_W'(1)));
    end

endmodule

FILE: rtl/core/bbx_window.sv
// Window stage: two line stores, the 3x3 window registers and the channel sums.
// Depends on bbx_pkg, bbx_ram and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_top_assert.svh"

module bbx_window #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  bbx_pkg::t_pos                i_tag,
    input  bbx_pkg::t_rgb                i_px,
    input  logic                         i_s2_free,
    output logic                         o_ready,
    output logic                         o_s2_load,
    output bbx_pkg::t_s2                 o_s2
);
    import bbx_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic          r_s1_vld;
    logic [CW-1:0] r_s1_col;
    t_pos          r_s1_tag;
    t_rgb          r_s1_px;
    t_rgb          r_win [6];

    logic              w_s1_fire;
    logic [RGB_W-1:0]  w_up_rd;
    logic [RGB_W-1:0]  w_mid_rd;
    t_rgb              w_up;
    t_rgb              w_mid;
    logic [8:0][PIX_W-1:0] w_vr;
    logic [8:0][PIX_W-1:0] w_vg;
    logic [8:0][PIX_W-1:0] w_vb;

    // stage handshake
    assign w_s1_fire = r_s1_vld && i_s2_free;
    assign o_ready   = !r_s1_vld || w_s1_fire;
    assign o_s2_load = w_s1_fire && (r_s1_tag.has_blur || r_s1_tag.has_pass);

    // line store of row r-2: takes the old row r-1 entry
    bbx_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_upper (
        .i_clk   (i_clk),
        .i_we    (w_s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (w_mid_rd),
        .i_re    (i_accept),
        .i_raddr (i_col),
        .o_rdata (w_up_rd)
    );

    // line store of row r-1: takes the new pixel
    bbx_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_middle (
        .i_clk   (i_clk),
        .i_we    (w_s1_fire),
        .i_waddr (r_s1_col),
        .i_wdata (r_s1_px),
        .i_re    (i_accept),
        .i_raddr (i_col),
        .o_rdata (w_mid_rd)
    );

    assign w_up  = w_up_rd;
    assign w_mid = w_mid_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_accept) begin
            r_s1_vld <= 1'b1;
        end else if (w_s1_fire) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_col <= i_col;
            r_s1_tag <= i_tag;
            r_s1_px  <= i_px;
        end
    end

    // window: slots 0..2 are column c-2, slots 3..5 column c-1 (rows r-2, r-1, r)
    always_ff @(posedge i_clk) begin
        if (w_s1_fire) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= w_up;
            r_win[4] <= w_mid;
            r_win[5] <= r_s1_px;
        end
    end

    // gather the nine taps per channel
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            w_vr[i] = r_win[i].red;
            w_vg[i] = r_win[i].green;
            w_vb[i] = r_win[i].blue;
        end
        w_vr[6] = w_up.red;
        w_vg[6] = w_up.green;
        w_vb[6] = w_up.blue;
        w_vr[7] = w_mid.red;
        w_vg[7] = w_mid.green;
        w_vb[7] = w_mid.blue;
        w_vr[8] = r_s1_px.red;
        w_vg[8] = r_s1_px.green;
        w_vb[8] = r_s1_px.blue;
    end

    always_comb begin
        o_s2.pos       = r_s1_tag;
        o_s2.sum_red   = sum9(w_vr);
        o_s2.sum_green = sum9(w_vg);
        o_s2.sum_blue  = sum9(w_vb);
        o_s2.px        = r_s1_px;
    end

    // a line-store write never lands on the column being read in the same cycle
    `BBX_ASSERT(a_no_rw_clash, w_s1_fire && i_accept |-> r_s1_col != i_col, "line store read/write clash")
    // blur needs two earlier columns in the window
    `BBX_ASSERT(a_blur_col, r_s1_vld && r_s1_tag.has_blur |-> r_s1_col >= CW'(2), "blur flagged in column 0 or 1")
    // a stalled item keeps its line-store data
    `BBX_ASSERT(a_rd_hold, r_s1_vld && !w_s1_fire |=> $stable(w_up_rd) && $stable(w_mid_rd), "line store data lost in stall")

endmodule

FILE: rtl/core/bbx_emit.sv
// Result stage: divides the sums by nine and sends one or two results per item.
// Depends on bbx_pkg, bbx_pix_out_if and the assertion macro header.
`timescale 1ns / 1ps
`include "rgb_box_blur_3x3_top_assert.svh"

module bbx_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  bbx_pkg::t_s2         i_s2,
    output logic                 o_free,
    bbx_pix_out_if.source        o_pix
);
    import bbx_pkg::*;

    logic r_s2_vld;
    logic r_blur_pend;
    t_s2  r_s2;
    logic r_out_vld;
    logic [ROW_W-1:0]  r_out_row;
    logic [OCOL_W-1:0] r_out_col;
    t_rgb              r_out_px;
    logic              r_out_last;

    logic n_s2_vld;
    logic n_blur_pend;
    logic n_out_vld;
    logic [ROW_W-1:0]  n_out_row;
    logic [OCOL_W-1:0] n_out_col;
    t_rgb              n_out_px;
    logic              n_out_last;

    logic w_out_free;
    logic w_emit;
    logic w_last;
    logic w_s2_done;

    // blurred result goes first, border pass-through last
    assign w_out_free = !r_out_vld || o_pix.ready;
    assign w_emit     = r_s2_vld && w_out_free;
    assign w_last     = r_blur_pend ? !r_s2.pos.has_pass : 1'b1;
    assign w_s2_done  = w_emit && w_last;
    assign o_free     = !r_s2_vld || w_s2_done;

    always_comb begin
        n_s2_vld    = r_s2_vld;
        n_blur_pend = r_blur_pend;
        if (i_load) begin
            n_s2_vld    = 1'b1;
            n_blur_pend = i_s2.pos.has_blur;
        end else if (w_s2_done) begin
            n_s2_vld    = 1'b0;
        end else if (w_emit) begin
            n_blur_pend = 1'b0;
        end
    end

    // output register
    always_comb begin
        n_out_vld  = r_out_vld && !o_pix.ready;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        n_out_px   = r_out_px;
        n_out_last = r_out_last;
        if (w_emit) begin
            n_out_vld  = 1'b1;
            n_out_last = w_last;
            if (r_blur_pend) begin
                n_out_row      = r_s2.pos.row - ROW_W'(1);
                n_out_col      = r_s2.pos.col - OCOL_W'(1);
                n_out_px.red   = div9(r_s2.sum_red);
                n_out_px.green = div9(r_s2.sum_green);
                n_out_px.blue  = div9(r_s2.sum_blue);
            end else begin
                n_out_row = r_s2.pos.row;
                n_out_col = r_s2.pos.col;
                n_out_px  = r_s2.px;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld    <= 1'b0;
            r_blur_pend <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_s2_vld    <= n_s2_vld;
            r_blur_pend <= n_blur_pend;
            r_out_vld   <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_s2 <= i_s2;
        end
        r_out_row  <= n_out_row;
        r_out_col  <= n_out_col;
        r_out_px   <= n_out_px;
        r_out_last <= n_out_last;
    end

    assign o_pix.valid       = r_out_vld;
    assign o_pix.out_row     = r_out_row;
    assign o_pix.out_col     = r_out_col;
    assign o_pix.out_red     = r_out_px.red;
    assign o_pix.out_green   = r_out_px.green;
    assign o_pix.out_blue    = r_out_px.blue;
    assign o_pix.last_in_run = r_out_last;

    // items without results never enter this stage
    `BBX_ASSERT(a_s2_nonempty, r_s2_vld |-> r_s2.pos.has_blur || r_s2.pos.has_pass, "empty item in result stage")
    `BBX_ASSERT(a_pend_blur, r_s2_vld && r_blur_pend |-> r_s2.pos.has_blur, "blur pending without blur flag")
    // a non-final result leaves its pass-through behind in this stage
    `BBX_ASSERT(a_run_cont, o_pix.valid && o_pix.ready && !o_pix.last_in_run |-> r_s2_vld && !r_blur_pend, "run split from its item")
    `BBX_ASSERT_ALL(a_rst_out, !i_rst_n |=> !o_pix.valid, "result valid after reset")

endmodule

FILE: rtl/core/rgb_box_blur_3x3_top.sv
// Channel   | Dir | Payload                                         | Handshake
// i_pix     | in  | in_red, in_green, in_blue                       | valid/ready
// o_pix     | out | out_row, out_col, out_red/green/blue, last_in_run | valid/ready
// i_cfg_*   | in  | index 0 frame_width, index 1 frame_height        | write enable
//
// One pixel item per clock while no stall holds i_pix.ready low. Accepted pixels are
// registered with their line-store read, the window sums go into the result-stage
// register and the divide into the output register. A pixel that ends a blurred
// run and is also a border pixel (last column or last row) gives two results.
// Synchronous active-low reset clears position, pipeline valids and sets
// 640x480; the line stores hold no reset and need no clearing pass.
// Output stalls back up through the result and window stages to i_pix.ready.
`timescale 1ns / 1ps

module rgb_box_blur_3x3_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  bbx_pkg::t_cfg_idx              i_cfg_idx,
    input  logic [bbx_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bbx_pix_in_if.sink                     i_pix,
    bbx_pix_out_if.source                  o_pix
);
    import bbx_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;

    logic          w_ready;
    logic          w_accept;
    logic [CW-1:0] w_col;
    t_pos          w_tag;
    t_rgb          w_px;
    logic          w_s2_free;
    logic          w_s2_load;
    t_s2           w_s2;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FW_W-1:0];
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign i_pix.ready = w_ready;
    assign w_accept    = i_pix.valid && w_ready;
    assign w_px.red    = i_pix.in_red;
    assign w_px.green  = i_pix.in_green;
    assign w_px.blue   = i_pix.in_blue;

    bbx_pos #(.MAX_WIDTH(MAX_WIDTH)) u_pos (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_col          (w_col),
        .o_tag          (w_tag)
    );

    bbx_window #(.MAX_WIDTH(MAX_WIDTH)) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_col     (w_col),
        .i_tag     (w_tag),
        .i_px      (w_px),
        .i_s2_free (w_s2_free),
        .o_ready   (w_ready),
        .o_s2_load (w_s2_load),
        .o_s2      (w_s2)
    );

    bbx_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s2_load),
        .i_s2    (w_s2),
        .o_free  (w_s2_free),
        .o_pix   (o_pix)
    );

endmodule

FILE: dv/rgb_box_blur_3x3_top_tb.sv
// Testbench for rgb_box_blur_3x3_top: streams raster pixels through the blur and
// checks every result item against a scoreboard that predicts blur and border output.
// Depends on bbx_pkg, bbx_pix_if and the RTL of the block.
`timescale 1ns / 1ps

module rgb_box_blur_3x3_top_tb;
    import bbx_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int TOTAL_ITEMS   = 370;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 60;
    localparam int IDLE_LIMIT    = 3000;
    localparam int MAX_REPORTS   = 40;

    typedef struct packed {
        logic [ROW_W-1:0]  row;
        logic [OCOL_W-1:0] col;
        t_rgb              px;
        logic              last;
    } out_pixel_t;

    // Predicts the blurred and border pixels and holds them until they come out
    class blur_scoreboard;
        logic [FW_W-1:0]   width_reg;
        logic [FH_W-1:0]   height_reg;
        logic [ROW_W-1:0]  row_pos;
        logic [OCOL_W-1:0] col_pos;
        t_rgb              upper_line [MAX_W];
        t_rgb              middle_line [MAX_W];
        t_rgb              win [6];
        out_pixel_t        due_q [$];
        int errors         = 0;
        int pixels_in      = 0;
        int results_out    = 0;
        int blurs_due      = 0;
        int passes_due     = 0;
        int frames_started = 0;
        int reg_writes     = 0;

        function new();
            width_reg  = FW_RESET;
            height_reg = FH_RESET;
            row_pos    = '0;
            col_pos    = '0;
            foreach (win[i]) win[i] = '0;
            foreach (upper_line[i]) begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_FRAME_WIDTH:  width_reg = value[FW_W-1:0];
                CFG_FRAME_HEIGHT: height_reg = value[FH_W-1:0];
                default: ;
            endcase
            reg_writes++;
        endfunction

        // widths below 3 act as 3, above the line store depth as the depth
        function int eff_w();
            if (width_reg < MIN_SIDE) return MIN_SIDE;
            if (width_reg > MAX_W) return MAX_W;
            return int'(width_reg);
        endfunction

        function int eff_h();
            if (height_reg < MIN_SIDE) return MIN_SIDE;
            return int'(height_reg);
        endfunction

        // row that the next pixel lands in, after any early row or frame end
        function int next_row();
            int r;
            r = row_pos;
            if (col_pos >= eff_w()) r++;
            if (r >= eff_h()) r = 0;
            return r;
        endfunction

        function int pending();
            return due_q.size();
        endfunction

        function void note_pixel(t_rgb px);
            int ew, eh, r, c, n, i;
            int sum_r, sum_g, sum_b;
            t_rgb up, mid;
            out_pixel_t res [2];
            ew = eff_w();
            eh = eff_h();
            r  = row_pos;
            c  = col_pos;
            n  = 0;
            pixels_in++;
            if (c >= ew) begin
                c = 0;
                r++;
            end
            if (r >= eh) r = 0;
            if (r == 0 && c == 0) frames_started++;
            up  = upper_line[c];
            mid = middle_line[c];

            // blurred pixel one row up and one column left is now complete
            if (r >= 2 && c >= 2) begin
                sum_r = int'(up.red) + int'(mid.red) + int'(px.red);
                sum_g = int'(up.green) + int'(mid.green) + int'(px.green);
                sum_b = int'(up.blue) + int'(mid.blue) + int'(px.blue);
                for (i = 0; i < 6; i++) begin
                    sum_r += int'(win[i].red);
                    sum_g += int'(win[i].green);
                    sum_b += int'(win[i].blue);
                end
                res[n].row      = ROW_W'(r - 1);
                res[n].col      = OCOL_W'(c - 1);
                res[n].px.red   = PIX_W'(sum_r / 9);
                res[n].px.green = PIX_W'(sum_g / 9);
                res[n].px.blue  = PIX_W'(sum_b / 9);
                res[n].last     = 1'b0;
                n++;
                blurs_due++;
            end
            // border pixels pass through unchanged
            if (r == 0 || r == eh - 1 || c == 0 || c == ew - 1) begin
                res[n].row  = ROW_W'(r);
                res[n].col  = OCOL_W'(c);
                res[n].px   = px;
                res[n].last = 1'b0;
                n++;
                passes_due++;
            end
            if (n > 0) res[n-1].last = 1'b1;
            for (i = 0; i < n; i++) due_q.push_back(res[i]);

            // shift line stores and the window
            upper_line[c]  = mid;
            middle_line[c] = px;
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = up;
            win[4] = mid;
            win[5] = px;

            if (c + 1 >= ew) begin
                col_pos = '0;
                row_pos = (r + 1 >= eh) ? '0 : ROW_W'(r + 1);
            end else begin
                col_pos = OCOL_W'(c + 1);
                row_pos = ROW_W'(r);
            end
        endfunction

        function void mismatch(string field, logic [31:0] want_v, logic [31:0] got_v,
                               out_pixel_t want);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s expected %0d got %0d (pixel row %0d col %0d)",
                         $time, field, want_v, got_v, want.row, want.col);
        endfunction

        function void check_result(out_pixel_t got);
            out_pixel_t want;
            results_out++;
            if (due_q.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display({"%0t: result with none expected: expected nothing ",
                              "got row %0d col %0d rgb %h"},
                             $time, got.row, got.col, got.px);
                return;
            end
            want = due_q.pop_front();
            if (got.row !== want.row) mismatch("row", want.row, got.row, want);
            if (got.col !== want.col) mismatch("col", want.col, got.col, want);
            if (got.px.red !== want.px.red) mismatch("red", want.px.red, got.px.red, want);
            if (got.px.green !== want.px.green)
                mismatch("green", want.px.green, got.px.green, want);
            if (got.px.blue !== want.px.blue)
                mismatch("blue", want.px.blue, got.px.blue, want);
            if (got.last !== want.last) mismatch("last_in_run", want.last, got.last, want);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    bbx_pix_in_if  pix_in_bus ();
    bbx_pix_out_if pix_out_bus ();

    blur_scoreboard sb = new();

    int sent_count  = 0;
    int idle_cycles = 0;
    int hold_offs   = 0;
    bit quiet_src   = 1'b0;
    bit sink_steady = 1'b0;
    bit hold_off_req = 1'b0;

    rgb_box_blur_3x3_top #(
        .MAX_WIDTH (MAX_W)
    ) u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pix      (pix_in_bus),
        .o_pix      (pix_out_bus)
    );

    // 100 MHz clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Monitor: note accepted pixels, check accepted results, count idle cycles
    always @(posedge clk) begin
        out_pixel_t got;
        if (rst_n) begin
            if (pix_in_bus.valid && pix_in_bus.ready)
                sb.note_pixel({pix_in_bus.in_red, pix_in_bus.in_green, pix_in_bus.in_blue});
            if (pix_out_bus.valid && pix_out_bus.ready) begin
                got.row      = pix_out_bus.out_row;
                got.col      = pix_out_bus.out_col;
                got.px.red   = pix_out_bus.out_red;
                got.px.green = pix_out_bus.out_green;
                got.px.blue  = pix_out_bus.out_blue;
                got.last     = pix_out_bus.last_in_run;
                sb.check_result(got);
            end
            if ((pix_in_bus.valid && pix_in_bus.ready) ||
                (pix_out_bus.valid && pix_out_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Watchdog: nothing accepted for too long
    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge clk);
        $display("%0t: no item accepted for %0d cycles", $time, IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // Output sink: random stalls, steady stretches and requested long hold-offs
    initial begin
        int len;
        int k;
        pix_out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                pix_out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
                hold_offs++;
            end else if (sink_steady) begin
                pix_out_bus.ready <= 1'b1;
                @(posedge clk);
            end else begin
                k = $urandom_range(0, 99);
                if (k < 65) begin
                    pix_out_bus.ready <= 1'b1;
                    len = $urandom_range(1, 16);
                end else if (k < 94) begin
                    pix_out_bus.ready <= 1'b0;
                    len = $urandom_range(1, 3);
                end else begin
                    pix_out_bus.ready <= 1'b0;
                    len = $urandom_range(10, 40);
                end
                repeat (len) @(posedge clk);
            end
        end
    end

    function automatic logic [PIX_W-1:0] rand_chan();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return '0;
        if (k == 1) return '1;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    function automatic t_rgb rand_pixel();
        t_rgb p;
        p.red   = rand_chan();
        p.green = rand_chan();
        p.blue  = rand_chan();
        return p;
    endfunction

    // mostly narrow frames, now and then below minimum or wide
    function automatic logic [CFG_DATA_W-1:0] pick_width();
        int k;
        k = $urandom_range(0, 19);
        if (k == 0) return CFG_DATA_W'($urandom_range(0, 2));
        if (k == 1) return CFG_DATA_W'($urandom_range(13, 40));
        if (k == 2) return CFG_DATA_W'($urandom);
        return CFG_DATA_W'($urandom_range(3, 10));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_height();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return CFG_DATA_W'($urandom_range(0, 2));
        if (k == 1) return CFG_DATA_W'($urandom_range(7, 65535));
        return CFG_DATA_W'($urandom_range(3, 6));
    endfunction

    task automatic source_gap();
        int len;
        int k;
        k = $urandom_range(0, 99);
        len = (k < 60) ? 0 : (k < 92) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        if (len > 0) begin
            pix_in_bus.valid <= 1'b0;
            repeat (len) @(posedge clk);
        end
    endtask

    // offer one pixel item and hold it until accepted
    task automatic send_pixel(input t_rgb px);
        pix_in_bus.valid    <= 1'b1;
        pix_in_bus.in_red   <= px.red;
        pix_in_bus.in_green <= px.green;
        pix_in_bus.in_blue  <= px.blue;
        do @(posedge clk); while (!pix_in_bus.ready);
        sent_count++;
        if (!quiet_src) source_gap();
    endtask

    // stop the source, wait for every due result, then let the pipeline empty
    task automatic wait_for_results();
        pix_in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge clk);
    endtask

    // Stimulus
    initial begin
        int phase;
        int n;
        int ew;
        int frame_px;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= CFG_FRAME_WIDTH;
        cfg_data            <= '0;
        pix_in_bus.valid    <= 1'b0;
        pix_in_bus.in_red   <= '0;
        pix_in_bus.in_green <= '0;
        pix_in_bus.in_blue  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 640x480: first row passes through
        send_pixel(t_rgb'(24'h000000));
        send_pixel(t_rgb'(24'hFFFFFF));
        send_pixel(t_rgb'(24'h5AA53C));

        // all-ones width clamps to the line store depth, grown on row 0
        wait_for_results();
        write_reg(CFG_FRAME_WIDTH, 16'hFFFF);
        send_pixel(t_rgb'(24'h0FF081));
        send_pixel(t_rgb'(24'h7E18E7));

        // shrink width below the position: row ends early; zero height acts as 3
        wait_for_results();
        write_reg(CFG_FRAME_WIDTH, 16'd3);
        write_reg(CFG_FRAME_HEIGHT, 16'd0);
        repeat (6) send_pixel(rand_pixel());

        // tallest frame, saturated pixels give the largest sums
        wait_for_results();
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        repeat (12) send_pixel(t_rgb'(24'hFFFFFF));

        // shrink height below the current row: frame ends early
        wait_for_results();
        write_reg(CFG_FRAME_HEIGHT, 16'd3);
        write_reg(CFG_FRAME_WIDTH, 16'd1024);

        // random phases of frames, partial frames and size changes
        phase = 0;
        while (sent_count < TOTAL_ITEMS) begin
            wait_for_results();
            if ($urandom_range(0, 9) < 7) begin
                if ($urandom_range(0, 1) == 1) write_reg(CFG_FRAME_HEIGHT, pick_height());
                // width may grow only while row 0 is being filled
                ew = sb.eff_w();
                if (sb.next_row() == 0 && $urandom_range(0, 3) != 0)
                    write_reg(CFG_FRAME_WIDTH, pick_width());
                else if ($urandom_range(0, 2) == 0)
                    write_reg(CFG_FRAME_WIDTH,
                              CFG_DATA_W'($urandom_range(3, (ew < 12) ? ew : 12)));
            end
            quiet_src   = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            frame_px    = sb.eff_w() * sb.eff_h();
            if ($urandom_range(0, 2) == 0 || frame_px > 60)
                n = $urandom_range(1, (frame_px < 120) ? frame_px : 120);
            else
                n = frame_px * $urandom_range(1, 2);
            // one long output hold-off against a full-rate source
            if (phase == 1) begin
                quiet_src    = 1'b1;
                sink_steady  = 1'b0;
                hold_off_req = 1'b1;
                if (n < 48) n = 48;
            end
            // keep the total close to the planned item count
            if (n > TOTAL_ITEMS - sent_count) n = TOTAL_ITEMS - sent_count;
            repeat (n) send_pixel(rand_pixel());
            phase++;
        end

        pix_in_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        $display("run: %0d pixels in, %0d results checked (%0d blurred, %0d border), %0d frames",
                 sb.pixels_in, sb.results_out, sb.blurs_due, sb.passes_due, sb.frames_started);
        $display("run: %0d register writes over %0d phases, %0d long output hold-offs",
                 sb.reg_writes, phase, hold_offs);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
